// ===== hdl/xml_character_escaper_defines.svh =====
// Assertion macros shared by the XML character escaper RTL.
`ifndef XML_CHARACTER_ESCAPER_DEFINES_SVH
`define XML_CHARACTER_ESCAPER_DEFINES_SVH
`ifndef SYNTHESIS
`define XCE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("xce: assertion failed");
`define XCE_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("xce: forbidden condition seen");
`else
`define XCE_ASSERT(lbl, clk, rst, prop)
`define XCE_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== hdl/xce_pkg.sv =====
// Types, constants and helpers of the XML character escaper.
package xce_pkg;

   localparam int CODE_BITS_DEFAULT = 21;
   localparam int CHAR_BITS         = 21;
   localparam int LEN_BITS          = 4;   // longest escape is 12 chars at 32-bit codes
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [2:0] KIND_PLAIN = 3'd0;
   localparam logic [2:0] KIND_AMP   = 3'd1;
   localparam logic [2:0] KIND_LT    = 3'd2;
   localparam logic [2:0] KIND_GT    = 3'd3;
   localparam logic [2:0] KIND_CTRL  = 3'd4;
   localparam logic [2:0] KIND_HEX   = 3'd5;

   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_TILD = 8'h7E;
   localparam logic [7:0] CH_E    = 8'h45;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_M    = 8'h6D;
   localparam logic [7:0] CH_P    = 8'h70;
   localparam logic [7:0] CH_LL   = 8'h6C;
   localparam logic [7:0] CH_G    = 8'h67;
   localparam logic [7:0] CH_T    = 8'h74;
   localparam logic [7:0] CH_X    = 8'h78;

   typedef struct packed {
      logic [2:0]          kind;
      logic [LEN_BITS-1:0] len;
   } desc_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (CH_0 + {4'd0, nib}) : (CH_A + {4'd0, nib} - 8'd10);
   endfunction

endpackage

// ===== hdl/xce_front.sv =====
// Front end: accepts input words, drops terminators and classifies the escape.
module xce_front #(
   parameter int CODE_BITS = xce_pkg::CODE_BITS_DEFAULT
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CODE_BITS-1:0] req_code_point,
   input  logic                 q_ready,
   output logic                 q_push,
   output xce_pkg::desc_type    q_desc,
   output logic [CODE_BITS-1:0] q_code
);
   import xce_pkg::*;

   localparam int NIBBLES  = (CODE_BITS + 3) / 4;
   localparam int NIB_W    = $clog2(NIBBLES);
   localparam int EXT_BITS = 4 * (1 << NIB_W);

   logic [EXT_BITS-1:0] code_ext;
   logic [LEN_BITS-1:0] top_nib;
   logic [2:0]          kind;
   logic [LEN_BITS-1:0] len;

   assign code_ext = EXT_BITS'(req_code_point);

   // highest nonzero nibble sets the hex digit count
   always_comb begin
      top_nib = '0;
      for (int i = 1; i < NIBBLES; i++) begin
         if (|code_ext[4*i +: 4]) begin
            top_nib = LEN_BITS'(i);
         end
      end
   end

   always_comb begin
      priority if (req_code_point == CODE_BITS'(CH_AMP)) begin
         kind = KIND_AMP;
         len  = LEN_BITS'(5);
      end else if (req_code_point == CODE_BITS'(CH_LT)) begin
         kind = KIND_LT;
         len  = LEN_BITS'(4);
      end else if (req_code_point == CODE_BITS'(CH_GT)) begin
         kind = KIND_GT;
         len  = LEN_BITS'(4);
      end else if (req_code_point == CODE_BITS'(CH_TAB) ||
                   req_code_point == CODE_BITS'(CH_LF)) begin
         kind = KIND_PLAIN;
         len  = LEN_BITS'(1);
      end else if (req_code_point < CODE_BITS'(CH_SP)) begin
         kind = KIND_CTRL;
         len  = LEN_BITS'(8);
      end else if (req_code_point > CODE_BITS'(CH_TILD)) begin
         kind = KIND_HEX;
         len  = top_nib + LEN_BITS'(5);   // "&#x" + digits + ";"
      end else begin
         kind = KIND_PLAIN;
         len  = LEN_BITS'(1);
      end
   end

   assign req_ready   = q_ready;
   assign q_push      = req_valid && q_ready && (req_code_point != '0);
   assign q_desc.kind = kind;
   assign q_desc.len  = len;
   assign q_code      = req_code_point;

endmodule

// ===== hdl/xce_queue.sv =====
// Two-entry queue of classified words between front and back end.
`include "xml_character_escaper_defines.svh"
module xce_queue #(
   parameter int CODE_BITS = xce_pkg::CODE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  xce_pkg::desc_type    push_desc,
   input  logic [CODE_BITS-1:0] push_code,
   output logic                 push_ready,
   output logic                 head_valid,
   output xce_pkg::desc_type    head_desc,
   output logic [CODE_BITS-1:0] head_code,
   input  logic                 pop
);
   import xce_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type             desc_ff [QUEUE_DEPTH];
   logic [CODE_BITS-1:0] code_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = desc_ff[rd_ptr_ff];
   assign head_code  = code_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         desc_ff[wr_ptr_ff] <= push_desc;
         code_ff[wr_ptr_ff] <= push_code;
      end
   end

   `XCE_NEVER(a_no_overflow, clock, reset, push && !push_ready)
   `XCE_NEVER(a_no_underflow, clock, reset, pop && !head_valid)
   `XCE_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH))

endmodule

// ===== hdl/xce_back.sv =====
// Back end: walks each queued word through its escape sequence, one char per cycle unless rsp_ready stalls.
`include "xml_character_escaper_defines.svh"
module xce_back #(
   parameter int CODE_BITS = xce_pkg::CODE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  xce_pkg::desc_type             q_desc,
   input  logic [CODE_BITS-1:0]          q_code,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [xce_pkg::CHAR_BITS-1:0] rsp_out_char,
   output logic                          rsp_last
);
   import xce_pkg::*;

   localparam int NIBBLES  = (CODE_BITS + 3) / 4;
   localparam int NIB_W    = $clog2(NIBBLES);
   localparam int EXT_BITS = 4 * (1 << NIB_W);

   logic [LEN_BITS-1:0]  idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [CHAR_BITS-1:0] char_ff;
   logic                 last_ff;

   logic                 load;
   logic                 emit;
   logic                 is_last;
   logic [EXT_BITS-1:0]  code_ext;
   logic [LEN_BITS-1:0]  nib_pos;
   logic [3:0]           hex_nib;
   logic [7:0]           ascii;

   assign load    = !valid_ff || rsp_ready;
   assign emit    = load && q_valid;
   assign is_last = (idx_ff == q_desc.len - 1'b1);
   assign q_pop   = emit && is_last;

   // hex digits go out most significant first; nibble = len - 2 - idx
   assign code_ext = EXT_BITS'(q_code);
   assign nib_pos  = q_desc.len - LEN_BITS'(2) - idx_ff;
   assign hex_nib  = code_ext[4*nib_pos[NIB_W-1:0] +: 4];

   always_comb begin
      ascii = CH_SEMI;
      unique case (q_desc.kind)
         KIND_AMP: begin
            unique case (idx_ff)
               LEN_BITS'(0): ascii = CH_AMP;
               LEN_BITS'(1): ascii = CH_A;
               LEN_BITS'(2): ascii = CH_M;
               LEN_BITS'(3): ascii = CH_P;
               default:      ascii = CH_SEMI;
            endcase
         end
         KIND_LT, KIND_GT: begin
            unique case (idx_ff)
               LEN_BITS'(0): ascii = CH_AMP;
               LEN_BITS'(1): ascii = (q_desc.kind == KIND_LT) ? CH_LL : CH_G;
               LEN_BITS'(2): ascii = CH_T;
               default:      ascii = CH_SEMI;
            endcase
         end
         KIND_CTRL: begin
            unique case (idx_ff)
               LEN_BITS'(0): ascii = CH_AMP;
               LEN_BITS'(1): ascii = CH_HASH;
               LEN_BITS'(2): ascii = CH_X;
               LEN_BITS'(3): ascii = CH_E;
               LEN_BITS'(4): ascii = CH_0;
               LEN_BITS'(5): ascii = hex_char(code_ext[7:4]);
               LEN_BITS'(6): ascii = hex_char(code_ext[3:0]);
               default:      ascii = CH_SEMI;
            endcase
         end
         KIND_HEX: begin
            priority if (idx_ff == LEN_BITS'(0)) begin
               ascii = CH_AMP;
            end else if (idx_ff == LEN_BITS'(1)) begin
               ascii = CH_HASH;
            end else if (idx_ff == LEN_BITS'(2)) begin
               ascii = CH_X;
            end else if (is_last) begin
               ascii = CH_SEMI;
            end else begin
               ascii = hex_char(hex_nib);
            end
         end
         default: begin
            ascii = {1'b0, code_ext[6:0]};   // plain printable, tab or newline
         end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = load ? q_valid : valid_ff;
      if (emit) begin
         idx_in = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= CHAR_BITS'(ascii);
         last_ff <= is_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last     = last_ff;

   `XCE_ASSERT(a_idx_in_range, clock, reset, q_valid |-> (idx_ff < q_desc.len))
   `XCE_ASSERT(a_mid_word_held, clock, reset, (idx_ff != '0) |-> q_valid)
   `XCE_ASSERT(a_pop_marks_last, clock, reset, q_pop |=> (rsp_valid && rsp_last))

endmodule

// ===== hdl/xml_character_escaper.sv =====
// XML character escaper: one code point in, its escaped characters out; a zero code point is dropped.
// An accepted word is written into the queue; its chars then go out through the output register.
// The back-end char sequencer sends one char per cycle while rsp_ready does not stall the output;
// an escape has 1 char for plain text and a hex escape has up to 4 + ceil(CODE_BITS/4) chars.
// A two-word queue lets input flow while the output register is stalled.
// Synchronous active-high reset empties the queue and the output register.
module xml_character_escaper #(
   parameter int CODE_BITS = xce_pkg::CODE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CODE_BITS-1:0]          req_code_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [xce_pkg::CHAR_BITS-1:0] rsp_out_char,
   output logic                          rsp_last
);
   import xce_pkg::*;

   logic                 push;
   logic                 push_ready;
   desc_type             push_desc;
   logic [CODE_BITS-1:0] push_code;
   logic                 head_valid;
   desc_type             head_desc;
   logic [CODE_BITS-1:0] head_code;
   logic                 pop;

   xce_front #(.CODE_BITS(CODE_BITS)) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_point (req_code_point),
      .q_ready        (push_ready),
      .q_push         (push),
      .q_desc         (push_desc),
      .q_code         (push_code)
   );

   xce_queue #(.CODE_BITS(CODE_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .push_code  (push_code),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .head_code  (head_code),
      .pop        (pop)
   );

   xce_back #(.CODE_BITS(CODE_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (head_valid),
      .q_desc       (head_desc),
      .q_code       (head_code),
      .q_pop        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule
